@@ sv/cpu_interrupt_dispatch_defines.svh @@
// assertion macros for the interrupt dispatch block
`ifndef CPU_INTERRUPT_DISPATCH_DEFINES_SVH
`define CPU_INTERRUPT_DISPATCH_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CID_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("interrupt dispatch check failed");
`define CID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("interrupt dispatch check failed");
`else
`define CID_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CID_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/cid_pkg.sv @@
// types and constants shared by the interrupt dispatch modules
`default_nettype none

package cid_pkg;

	localparam int NUM_LINES = 5;
	localparam logic [7:0] LINE_MASK = 8'((1 << NUM_LINES) - 1);
	localparam logic [15:0] VEC_BASE = 16'h0040;
	localparam logic [15:0] VEC_STRIDE = 16'd8;
	localparam logic [4:0] DISPATCH_CYCLES = 5'd20;
	localparam logic [4:0] WAKE_CYCLES = 5'd4;
	localparam logic [2:0] WAKE_LINE_LIMIT = 3'd2;
	localparam logic [3:0] LINE_COUNT = 4'(NUM_LINES);

	typedef enum logic [2:0] {
		OP_LINE       = 3'd0,
		OP_WR_ENABLE  = 3'd1,
		OP_WR_FLAGS   = 3'd2,
		OP_HALT       = 3'd3,
		OP_MASTER_ON  = 3'd4,
		OP_MASTER_OFF = 3'd5,
		OP_CHECK      = 3'd6
	} op_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [2:0]  line;
		logic        level;
		logic [7:0]  value;
		logic [15:0] cur_pc;
		logic [15:0] cur_sp;
		logic        halt_pending;
	} item_t;

	typedef struct packed {
		logic        taken;
		logic        woke;
		logic [15:0] next_pc;
		logic [15:0] next_sp;
		logic [15:0] push_word;
		logic [2:0]  ack_line;
		logic [4:0]  extra_cycles;
		logic        repeat_fetch;
		logic        halted_now;
		logic        master_enabled;
		logic [7:0]  pending_flags;
	} result_t;

endpackage

`default_nettype wire

@@ sv/cpu_interrupt_dispatch.sv @@
// Interrupt dispatch unit: takes one item per clock while the output is not stalled,
// and returns one result item for each. An item passes an input register, the single-pass
// dispatch logic that also updates the interrupt state, and a result register. The result
// item is presented once it has passed the input register and the result register, which
// waits while the output stalls; items may follow back to back. The result register lets
// the next item be accepted while a finished result still waits downstream. halt_bug_mode
// resets to 1 and should be written only while no item is in flight.
`default_nettype none
`include "cpu_interrupt_dispatch_defines.svh"

module cpu_interrupt_dispatch (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// line, level, value, cur_pc, cur_sp, halt_pending
	input  wire logic [47:0] s_tdata,
	// operation
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// taken, woke, next_pc, next_sp, push_word, ack_line, extra_cycles,
	// repeat_fetch, halted_now, master_enabled, pending_flags
	output logic [71:0]      m_tdata
);

	logic              halt_bug_mode_q;
	cid_pkg::item_t    item_s1;
	logic              valid_s1;
	cid_pkg::result_t  res_comb;
	cid_pkg::result_t  res_s2;
	logic              valid_s2;
	logic              adv;
	logic              fire;

	assign adv = !valid_s2 || m_tready;
	assign fire = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halt_bug_mode_q <= 1'b1;
		end else if (cfg_we) begin
			halt_bug_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.operation <= s_tuser;
			item_s1.line <= s_tdata[2:0];
			item_s1.level <= s_tdata[3];
			item_s1.value <= s_tdata[11:4];
			item_s1.cur_pc <= s_tdata[27:12];
			item_s1.cur_sp <= s_tdata[43:28];
			item_s1.halt_pending <= s_tdata[44];
		end
	end

	cid_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.halt_bug_mode (halt_bug_mode_q),
		.item          (item_s1),
		.res           (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata = {3'b000,
		res_s2.pending_flags,
		res_s2.master_enabled,
		res_s2.halted_now,
		res_s2.repeat_fetch,
		res_s2.extra_cycles,
		res_s2.ack_line,
		res_s2.push_word,
		res_s2.next_sp,
		res_s2.next_pc,
		res_s2.woke,
		res_s2.taken};

	`CID_ASSERT_IMPL(a_taken_clears_master, clk, arst_n, valid_s2 && res_s2.taken, !res_s2.master_enabled && res_s2.extra_cycles >= cid_pkg::DISPATCH_CYCLES)
	`CID_ASSERT_IMPL(a_woke_not_halted, clk, arst_n, valid_s2 && res_s2.woke, !res_s2.halted_now)
	`CID_ASSERT_IMPL(a_repeat_needs_wake, clk, arst_n, valid_s2 && res_s2.repeat_fetch, res_s2.woke && !res_s2.taken)
	`CID_ASSERT_IMPL(a_stall_only_downstream, clk, arst_n, !s_tready, valid_s1 && valid_s2 && !m_tready)
	`CID_ASSERT_NEXT(a_fire_lands, clk, arst_n, fire, valid_s2)

endmodule

`default_nettype wire

@@ sv/cid_core.sv @@
// interrupt state registers and single-pass dispatch logic
`default_nettype none

module cid_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire logic            halt_bug_mode,
	input  wire cid_pkg::item_t  item,
	output cid_pkg::result_t     res
);

	logic [7:0] enable_mask_q, enable_mask_d;
	logic [7:0] pending_q, pending_d;
	logic       master_enable_q, master_enable_d;
	logic       halted_q, halted_d;
	logic       enable_delay_q, enable_delay_d;
	logic       halt_latched_q, halt_latched_d;

	logic [7:0]  req;
	logic [2:0]  pick;
	logic [7:0]  pick_bit;
	logic [7:0]  line_bit;
	logic [15:0] pc;
	logic [15:0] sp;
	logic [15:0] push;
	logic [2:0]  ack;
	logic [4:0]  cycles;
	logic        taken;
	logic        woke;
	logic        rep;

	always_comb begin
		req = enable_mask_q & pending_q & cid_pkg::LINE_MASK;
		pick = '0;
		for (int i = cid_pkg::NUM_LINES - 1; i >= 0; i--) begin
			if (req[i]) begin
				pick = 3'(i);
			end
		end
		pick_bit = 8'd1 << pick;
		line_bit = 8'd1 << item.line;
	end

	always_comb begin
		enable_mask_d = enable_mask_q;
		pending_d = pending_q;
		master_enable_d = master_enable_q;
		halted_d = halted_q;
		enable_delay_d = enable_delay_q;
		halt_latched_d = halt_latched_q;
		pc = item.cur_pc;
		sp = item.cur_sp;
		push = '0;
		ack = '0;
		cycles = '0;
		taken = 1'b0;
		woke = 1'b0;
		rep = 1'b0;
		unique case (item.operation)
			cid_pkg::OP_LINE: begin
				if ({1'b0, item.line} < cid_pkg::LINE_COUNT) begin
					if (item.level) begin
						pending_d = pending_q | line_bit;
					end else begin
						pending_d = pending_q & ~line_bit;
					end
				end
			end
			cid_pkg::OP_WR_ENABLE: begin
				enable_mask_d = item.value;
			end
			cid_pkg::OP_WR_FLAGS: begin
				pending_d = item.value;
			end
			cid_pkg::OP_HALT: begin
				halted_d = 1'b1;
				halt_latched_d = item.halt_pending;
			end
			cid_pkg::OP_MASTER_ON: begin
				master_enable_d = 1'b1;
				enable_delay_d = 1'b1;
			end
			cid_pkg::OP_MASTER_OFF: begin
				master_enable_d = 1'b0;
			end
			cid_pkg::OP_CHECK: begin
				if (enable_delay_q) begin
					enable_delay_d = 1'b0;
				end else if (req != '0) begin
					if (halted_q) begin
						halted_d = 1'b0;
						woke = 1'b1;
						pending_d = pending_d & ~pick_bit;
						pc = pc + 16'd1;
						if (halt_bug_mode) begin
							rep = !master_enable_q && halt_latched_q;
						end else if (pick < cid_pkg::WAKE_LINE_LIMIT) begin
							cycles = cid_pkg::WAKE_CYCLES;
						end
					end
					if (master_enable_q) begin
						master_enable_d = 1'b0;
						pending_d = pending_d & ~pick_bit;
						taken = 1'b1;
						ack = pick;
						cycles = cycles + cid_pkg::DISPATCH_CYCLES;
						sp = sp - 16'd2;
						push = pc;
						pc = cid_pkg::VEC_BASE + 16'(pick) * cid_pkg::VEC_STRIDE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q <= '0;
			pending_q <= '0;
			master_enable_q <= 1'b0;
			halted_q <= 1'b0;
			enable_delay_q <= 1'b0;
			halt_latched_q <= 1'b0;
		end else if (fire) begin
			enable_mask_q <= enable_mask_d;
			pending_q <= pending_d;
			master_enable_q <= master_enable_d;
			halted_q <= halted_d;
			enable_delay_q <= enable_delay_d;
			halt_latched_q <= halt_latched_d;
		end
	end

	always_comb begin
		res.taken = taken;
		res.woke = woke;
		res.next_pc = pc;
		res.next_sp = sp;
		res.push_word = push;
		res.ack_line = ack;
		res.extra_cycles = cycles;
		res.repeat_fetch = rep;
		res.halted_now = halted_d;
		res.master_enabled = master_enable_d;
		res.pending_flags = pending_d;
	end

endmodule

`default_nettype wire
